// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants
// Event codes, phases, variants, register indexes and the result/state structs
// of the congestion window engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_LOSS = 2'd2;
  localparam logic [1:0] OP_RTT  = 2'd3;

  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_RECOV = 2'd2;
  localparam logic [1:0] PH_BBR   = 2'd3;

  localparam logic [1:0] VAR_RENO    = 2'd0;
  localparam logic [1:0] VAR_NEWRENO = 2'd1;
  localparam logic [1:0] VAR_BBR     = 2'd2;

  localparam logic [1:0] CFG_START_WINDOW    = 2'd0;
  localparam logic [1:0] CFG_START_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_VARIANT         = 2'd2;
  localparam logic [1:0] CFG_BOTTLENECK_RATE = 2'd3;

  localparam logic [15:0] WINDOW_RESET = 16'd1;
  localparam logic [15:0] THRESH_RESET = 16'd10000;
  localparam logic [15:0] RATE_RESET   = 16'd1;
  localparam logic [15:0] RTT_RESET    = 16'd1;
  localparam logic [5:0]  NO_BAND      = 6'd63;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ack_number;
    logic [5:0]  band;
    logic [15:0] rtt_sample;
  } item_t;

  typedef struct packed {
    logic [15:0] window;
    logic [15:0] threshold;
    logic [15:0] round_trip;
    logic [15:0] cap;
    logic [31:0] window_start;
    logic [31:0] window_end;
    logic [1:0]  phase;
    logic [5:0]  last_band;
  } state_t;

  typedef struct packed {
    logic        sent;
    logic [31:0] window_end_now;
    logic [15:0] window_now;
    logic [15:0] threshold_now;
    logic [1:0]  phase_now;
    logic        timed_out;
  } result_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

  // floor(log2(v)); zero has no band
  function automatic logic [5:0] band_of(input logic [31:0] v);
    logic [5:0] b;
    b = NO_BAND;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        b = 6'(i);
      end
    end
    band_of = b;
  endfunction

endpackage

// File: rtl/tcw_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_update: per-event state update
// Combinational next state and result for one registered item.
// ----------------------------------------------------------------------------
module tcw_update (
  input  tcw_pkg::item_t   item,
  input  tcw_pkg::state_t  st,
  input  logic [15:0]      start_window,
  input  logic [1:0]       variant,
  input  logic [15:0]      bottleneck_rate,
  output tcw_pkg::state_t  st_nxt,
  output tcw_pkg::result_t res
);

  logic [31:0] in_flight;
  logic [15:0] win_dbl;
  logic [15:0] win_inc;
  logic [31:0] rtt_prod;
  logic        sent;
  logic        timed_out;

  assign in_flight = st.window_end - st.window_start;
  assign win_dbl   = st.window[15] ? 16'hFFFF : {st.window[14:0], 1'b0};
  assign win_inc   = (st.window == 16'hFFFF) ? 16'hFFFF : st.window + 16'd1;
  assign rtt_prod  = 32'(item.rtt_sample) * 32'(bottleneck_rate);

  always_comb begin
    st_nxt    = st;
    sent      = 1'b0;
    timed_out = 1'b0;
    case (item.op)
      tcw_pkg::OP_SEND: begin
        if (in_flight < {16'd0, st.window}) begin
          st_nxt.window_end = st.window_end + 32'd1;
          sent              = 1'b1;
        end
      end
      tcw_pkg::OP_ACK: begin
        if (item.ack_number > st.window_start) begin
          st_nxt.window_start = item.ack_number;
          case (st.phase)
            tcw_pkg::PH_BBR:   st_nxt.window = st.cap;
            tcw_pkg::PH_AVOID: st_nxt.window = win_inc;
            tcw_pkg::PH_SLOW: begin
              st_nxt.window = win_dbl;
              if (variant == tcw_pkg::VAR_BBR) begin
                if (win_dbl > st.cap) begin
                  st_nxt.window = st.cap;
                  st_nxt.phase  = tcw_pkg::PH_BBR;
                end
              end else if (win_dbl >= st.threshold) begin
                st_nxt.window = st.threshold;
                st_nxt.phase  = tcw_pkg::PH_AVOID;
              end
            end
            default: ;
          endcase
        end else begin
          // stale ack: timeout
          st_nxt.window_end = st.window_end - 32'd1;
          st_nxt.threshold  = {1'b0, st.window[15:1]};
          st_nxt.window     = start_window;
          st_nxt.phase      = tcw_pkg::PH_SLOW;
          timed_out         = 1'b1;
        end
      end
      tcw_pkg::OP_LOSS: begin
        st_nxt.phase = tcw_pkg::PH_AVOID;
        if (!(variant == tcw_pkg::VAR_NEWRENO && item.band != tcw_pkg::NO_BAND &&
              item.band == st.last_band)) begin
          st_nxt.last_band = item.band;
          st_nxt.threshold = {1'b0, st.window[15:1]};
          st_nxt.window    = {1'b0, st.window[15:1]};
        end
      end
      default: begin
        st_nxt.round_trip = item.rtt_sample;
        st_nxt.cap        = tcw_pkg::sat16(rtt_prod);
      end
    endcase
  end

  assign res.sent           = sent;
  assign res.window_end_now = st_nxt.window_end;
  assign res.window_now     = st_nxt.window;
  assign res.threshold_now  = st_nxt.threshold;
  assign res.phase_now      = st_nxt.phase;
  assign res.timed_out      = timed_out;

endmodule

// File: rtl/tcw_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_out_reg: result register
// Holds one result item with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module tcw_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  tcw_pkg::result_t res,
  input  logic             out_stall,
  output logic             ready,
  output logic             out_valid,
  output tcw_pkg::result_t res_r
);

  logic out_valid_r;
  logic out_valid_nxt;

  assign ready         = !out_valid_r || !out_stall;
  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// File: rtl/tcp_congestion_window_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_congestion_window_control: sender congestion window engine
// Reno / NewReno / BBR-capped window control, one event per item.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    op, ack_number, lost_packet, rtt_sample
//   out      output     out_valid/out_stall  sent, window_end_now, window_now,
//                                            threshold_now, phase_now, timed_out
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// An item passes through the input register and then the result register;
// one item per cycle is sustained while out_stall is low.
// The loss band (log2 of lost_packet) is taken on input; the window cap
// (round trip times bottleneck rate) is kept in a register, updated by an rtt
// item or a rate write. Reset is synchronous and needs no clearing time.
// out_stall holds a valid result register and, once the input register is also
// full, raises in_stall.
// ----------------------------------------------------------------------------
module tcp_congestion_window_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_ack_number,
  input  logic [31:0] in_lost_packet,
  input  logic [15:0] in_rtt_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sent,
  output logic [31:0] out_window_end_now,
  output logic [15:0] out_window_now,
  output logic [15:0] out_threshold_now,
  output logic [1:0]  out_phase_now,
  output logic        out_timed_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic             item_valid_r;
  logic             item_valid_nxt;
  tcw_pkg::item_t   item_r;
  logic             accept;
  logic             fire;
  logic             out_ready;

  logic [15:0]      start_window_r;
  logic [1:0]       variant_r;
  logic [15:0]      rate_r;

  tcw_pkg::state_t  st_r;
  tcw_pkg::state_t  st_upd;
  tcw_pkg::state_t  st_nxt;
  tcw_pkg::result_t res;
  tcw_pkg::result_t res_r;
  logic [31:0]      cfg_prod;

  assign fire           = item_valid_r && out_ready;
  assign in_stall       = item_valid_r && !out_ready;
  assign accept         = in_valid && !in_stall;
  assign item_valid_nxt = accept ? 1'b1 : (item_valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op         <= in_op;
      item_r.ack_number <= in_ack_number;
      item_r.band       <= tcw_pkg::band_of(in_lost_packet);
      item_r.rtt_sample <= in_rtt_sample;
    end
  end

  tcw_update u_update (
    .item            (item_r),
    .st              (st_r),
    .start_window    (start_window_r),
    .variant         (variant_r),
    .bottleneck_rate (rate_r),
    .st_nxt          (st_upd),
    .res             (res)
  );

  assign cfg_prod = 32'(st_r.round_trip) * 32'(cfg_data);

  // start threshold only seeds the live threshold
  always_comb begin
    st_nxt = st_r;
    if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_START_WINDOW:    st_nxt.window    = cfg_data;
        tcw_pkg::CFG_START_THRESHOLD: st_nxt.threshold = cfg_data;
        tcw_pkg::CFG_BOTTLENECK_RATE: st_nxt.cap       = tcw_pkg::sat16(cfg_prod);
        default: ;
      endcase
    end else if (fire) begin
      st_nxt = st_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_window_r    <= tcw_pkg::WINDOW_RESET;
      variant_r         <= tcw_pkg::VAR_RENO;
      rate_r            <= tcw_pkg::RATE_RESET;
      st_r.window       <= tcw_pkg::WINDOW_RESET;
      st_r.threshold    <= tcw_pkg::THRESH_RESET;
      st_r.round_trip   <= tcw_pkg::RTT_RESET;
      st_r.cap          <= tcw_pkg::sat16(32'(tcw_pkg::RTT_RESET) * 32'(tcw_pkg::RATE_RESET));
      st_r.window_start <= 32'd0;
      st_r.window_end   <= 32'd0;
      st_r.phase        <= tcw_pkg::PH_SLOW;
      st_r.last_band    <= tcw_pkg::NO_BAND;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::CFG_START_WINDOW:    start_window_r <= cfg_data;
          tcw_pkg::CFG_VARIANT:         variant_r      <= cfg_data[1:0];
          tcw_pkg::CFG_BOTTLENECK_RATE: rate_r         <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  tcw_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .out_stall (out_stall),
    .ready     (out_ready),
    .out_valid (out_valid),
    .res_r     (res_r)
  );

  assign out_sent           = res_r.sent;
  assign out_window_end_now = res_r.window_end_now;
  assign out_window_now     = res_r.window_now;
  assign out_threshold_now  = res_r.threshold_now;
  assign out_phase_now      = res_r.phase_now;
  assign out_timed_out      = res_r.timed_out;

endmodule

// File: rtl/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_sent,
  input logic [31:0] out_window_end_now,
  input logic [1:0]  out_phase_now,
  input logic        out_timed_out
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_end_now))
    else $error("stalled result changed");

  a_sent_not_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_sent && out_timed_out))
    else $error("send and timeout in one item");

  a_timeout_slow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_phase_now == tcw_pkg::PH_SLOW)
    else $error("timeout did not enter slow start");

  a_no_recovery: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase_now != tcw_pkg::PH_RECOV)
    else $error("recovery phase reported");

endmodule

bind tcp_congestion_window_control tcw_checker u_tcw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_sent           (out_sent),
  .out_window_end_now (out_window_end_now),
  .out_phase_now      (out_phase_now),
  .out_timed_out      (out_timed_out)
);
